>>> sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Operation codes carried in the mode field
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } spq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic                capture;
        logic                do_enq;
        logic                do_deq;
        logic                load_result;
        logic [STATUS_W-1:0] result_code;
    } spq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic deq_op;
        logic empty;
        logic full;
    } spq_stat_t;

endpackage

`default_nettype wire

>>> sv/spq_datapath.sv
`default_nettype none

module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire spq_pkg::spq_cmd_t                   cmd,
    output spq_pkg::spq_stat_t                       stat,
    input  wire logic                                mode,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    output logic signed [spq_pkg::VALUE_W-1:0]       head_value,
    output logic [spq_pkg::STATUS_W-1:0]             status,
    output logic [spq_pkg::OCC_W-1:0]                occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                      mode_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [PRIO_W-1:0]  prio_reg;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;

    logic signed [VALUE_W-1:0] head_value_reg;
    logic [STATUS_W-1:0]       status_reg;

    logic signed [VALUE_W-1:0] slot_value_reg    [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]  slot_priority_reg [QUEUE_DEPTH];

    // Cell g holds an entry whose priority is strictly below the new one
    logic [QUEUE_DEPTH-1:0]    lt;

    logic [31:0]               count_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            value_reg <= item_value;
            prio_reg  <= item_priority;
        end
        if (cmd.load_result)
        begin
            head_value_reg <= cmd.do_deq ? slot_value_reg[0] : '0;
            status_reg     <= cmd.result_code;
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            lt[i] = (CW'(i) < count_reg) && (slot_priority_reg[i] < prio_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.do_deq)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic signed [VALUE_W-1:0] up_val;
        logic signed [PRIO_W-1:0]  up_pri;
        logic signed [VALUE_W-1:0] dn_val;
        logic signed [PRIO_W-1:0]  dn_pri;
        logic                      prev_lt;
        logic signed [VALUE_W-1:0] val_next;
        logic signed [PRIO_W-1:0]  pri_next;

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign up_val = slot_value_reg[g];
            assign up_pri = slot_priority_reg[g];
        end
        else
        begin : g_mid
            assign up_val = slot_value_reg[g+1];
            assign up_pri = slot_priority_reg[g+1];
        end

        if (g == 0)
        begin : g_first
            assign dn_val  = slot_value_reg[g];
            assign dn_pri  = slot_priority_reg[g];
            assign prev_lt = 1'b1;
        end
        else
        begin : g_rest
            assign dn_val  = slot_value_reg[g-1];
            assign dn_pri  = slot_priority_reg[g-1];
            assign prev_lt = lt[g-1];
        end

        always_comb
        begin
            val_next = slot_value_reg[g];
            pri_next = slot_priority_reg[g];
            if (cmd.do_deq)
            begin
                // advance toward the head
                val_next = up_val;
                pri_next = up_pri;
            end
            else if (cmd.do_enq && !lt[g])
            begin
                if (prev_lt)
                begin
                    val_next = value_reg;
                    pri_next = prio_reg;
                end
                else
                begin
                    val_next = dn_val;
                    pri_next = dn_pri;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            slot_value_reg[g]    <= val_next;
            slot_priority_reg[g] <= pri_next;
        end
    end

    assign count_ext   = 32'(count_reg);
    assign stat.deq_op = (mode_reg == MODE_DEQ);
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CW'(QUEUE_DEPTH));

    assign head_value = head_value_reg;
    assign status     = status_reg;
    assign occupancy  = count_ext[OCC_W-1:0];

endmodule

`default_nettype wire

>>> sv/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire spq_pkg::spq_stat_t  stat,
    output spq_pkg::spq_cmd_t        cmd
);
    import spq_pkg::*;

    spq_state_t state_reg;
    spq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        out_valid       = 1'b0;
        cmd.capture     = 1'b0;
        cmd.do_enq      = 1'b0;
        cmd.do_deq      = 1'b0;
        cmd.load_result = 1'b0;
        cmd.result_code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.load_result = 1'b1;
                if (stat.deq_op)
                begin
                    if (stat.empty)
                    begin
                        cmd.result_code = ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd.do_deq = 1'b1;
                    end
                end
                else
                begin
                    // drop the item when no slot is free
                    if (stat.full)
                    begin
                        cmd.result_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.do_enq = 1'b1;
                    end
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_enq && cmd.do_deq))
        else $error("enqueue and dequeue issued together");

    a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_enq |-> (!stat.full && !stat.deq_op))
        else $error("enqueue issued on full queue or dequeue transaction");

    a_deq_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_deq |-> (!stat.empty && stat.deq_op))
        else $error("dequeue issued on empty queue or enqueue transaction");

    a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> out_valid)
        else $error("result not presented after execute");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue reported full and empty");
`endif

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Sorted priority queue, smallest priority value served first.
// Input channel (in_valid / in_stall): mode 0 enqueues item_value with
// item_priority, mode 1 dequeues the head. An equal priority goes ahead of
// the entries already stored, so ties are served newest first.
// Output channel (out_valid / out_stall): exactly one result per input
// transaction with head_value (dequeued word, else 0), status (ok, underflow
// on empty dequeue, overflow on full enqueue, which drops the item) and
// occupancy (entry count after the operation).
// Sequence: an input transaction is taken in the idle state and its operands
// are registered; in the execute state the entry row is updated and the
// result is registered, and out_valid rises in the respond state. The
// controller sequences one transaction at a time through idle, execute and
// respond, so no new item is taken until the last result has been accepted.
// All slots compare against the new priority in parallel and shift by one
// place in the same cycle; the row has no search loop.
// A stalled result holds on the outputs and in_stall stays high until the
// result is taken. Reset empties the queue and leaves it ready for input.
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                mode,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [spq_pkg::VALUE_W-1:0]       head_value,
    output logic [spq_pkg::STATUS_W-1:0]             status,
    output logic [spq_pkg::OCC_W-1:0]                occupancy
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .head_value    (head_value),
        .status        (status),
        .occupancy     (occupancy)
    );

endmodule

`default_nettype wire

>>> tb/sv/spq_order_check.sv
`timescale 1ns / 100ps

module spq_order_check #(
    parameter int DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                mode,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [spq_pkg::VALUE_W-1:0]  head_value,
    input  logic [spq_pkg::STATUS_W-1:0]        status,
    input  logic [spq_pkg::OCC_W-1:0]           occupancy,
    output int                                  fail_count,
    output int                                  result_count,
    output int                                  pending,
    output int                                  underflow_count,
    output int                                  overflow_count
);
    import spq_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       code;
        logic [OCC_W-1:0]          occ;
    } queue_result_t;

    // Sorted shadow of the queue, slot 0 is the head
    logic signed [VALUE_W-1:0] row_value [DEPTH];
    logic signed [PRIO_W-1:0]  row_prio  [DEPTH];
    int                        row_count;
    queue_result_t             due_results [$];
    queue_result_t             want;

    function automatic queue_result_t queue_op_result(
        input logic                      op,
        input logic signed [VALUE_W-1:0] value,
        input logic signed [PRIO_W-1:0]  prio
    );
        queue_result_t r;
        int            pos;
        int            i;
        r.value = '0;
        r.code  = ST_OK;
        if (op == MODE_ENQ)
        begin
            if (row_count >= DEPTH)
                r.code = ST_OVERFLOW;
            else
            begin
                // go ahead of every entry with an equal or greater priority
                pos = 0;
                while (pos < row_count && row_prio[pos] < prio)
                    pos++;
                for (i = row_count; i > pos; i--)
                begin
                    row_value[i] = row_value[i-1];
                    row_prio[i]  = row_prio[i-1];
                end
                row_value[pos] = value;
                row_prio[pos]  = prio;
                row_count++;
            end
        end
        else
        begin
            if (row_count == 0)
                r.code = ST_UNDERFLOW;
            else
            begin
                r.value = row_value[0];
                for (i = 1; i < row_count; i++)
                begin
                    row_value[i-1] = row_value[i];
                    row_prio[i-1]  = row_prio[i];
                end
                row_count--;
            end
        end
        r.occ = OCC_W'(row_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count       = 0;
            due_results.delete();
            fail_count      = 0;
            result_count    = 0;
            pending         = 0;
            underflow_count = 0;
            overflow_count  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(queue_op_result(mode, item_value, item_priority));
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: head_value %0d status %0d occupancy %0d",
                             $time, head_value, status, occupancy);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.code == ST_UNDERFLOW)
                        underflow_count++;
                    if (want.code == ST_OVERFLOW)
                        overflow_count++;
                    if (head_value !== want.value)
                    begin
                        fail_count++;
                        $display("%0t: head_value expected %0d got %0d",
                                 $time, want.value, head_value);
                    end
                    if (status !== want.code)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d got %0d", $time, want.code, status);
                    end
                    if (occupancy !== want.occ)
                    begin
                        fail_count++;
                        $display("%0t: occupancy expected %0d got %0d",
                                 $time, want.occ, occupancy);
                    end
                end
            end
            pending = due_results.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      mode;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [PRIO_W-1:0]  item_priority;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [VALUE_W-1:0] head_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;

    int fail_count;
    int result_count;
    int pending;
    int underflow_count;
    int overflow_count;
    int cycle_count = 0;
    int sent        = 0;
    bit steady      = 1'b0;

    sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .head_value    (head_value),
        .status        (status),
        .occupancy     (occupancy)
    );

    spq_order_check #(.DEPTH(DEPTH)) order_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .item_value      (item_value),
        .item_priority   (item_priority),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .head_value      (head_value),
        .status          (status),
        .occupancy       (occupancy),
        .fail_count      (fail_count),
        .result_count    (result_count),
        .pending         (pending),
        .underflow_count (underflow_count),
        .overflow_count  (overflow_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("cycle limit reached with %0d results outstanding", sent - result_count);
        $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, two long hold-offs and a quiet stretch
    initial
    begin : result_side
        int hold_left;
        int stall_cycle;
        hold_left   = 0;
        stall_cycle = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            stall_cycle++;
            if (stall_cycle == 900 || stall_cycle == 2500)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_cycle >= 1300 && stall_cycle < 1900)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 10);
        end
    end

    task automatic offer(input logic op, input logic signed [VALUE_W-1:0] value,
                         input logic signed [PRIO_W-1:0] prio);
        in_valid      <= 1'b1;
        mode          <= op;
        item_value    <= value;
        item_priority <= prio;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Mix of tight tie-prone ranges, full-range words and the extremes
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        logic signed [PRIO_W-1:0] p;
        int                       sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            p = $urandom_range(0, 7);
            p = p - 4;
        end
        else if (sel < 8)
            p = $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0:       p = 32'sh8000_0000;
                1:       p = 32'sh7FFF_FFFF;
                2:       p = '0;
                default: p = '1;
            endcase
        end
        return p;
    endfunction

    initial
    begin : stimulus
        int   n;
        int   enq_pct;
        logic op;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        mode          <= MODE_ENQ;
        item_value    <= '0;
        item_priority <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty dequeue, extremes, a tie, fill to overflow, partial drain
        offer(MODE_DEQ, 32'sh1234_5678, 32'sh0);
        offer(MODE_ENQ, 32'sh7FFF_FFFF, 32'sh8000_0000);
        offer(MODE_ENQ, 32'sh8000_0000, 32'sh7FFF_FFFF);
        offer(MODE_ENQ, 32'sh0, 32'sh0);
        offer(MODE_ENQ, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        offer(MODE_ENQ, 32'sh5555_5555, 32'sh5);
        offer(MODE_ENQ, 32'shAAAA_AAAA, 32'sh5);
        for (n = 0; n < DEPTH - 6; n++)
            offer(MODE_ENQ, $urandom, pick_priority());
        offer(MODE_ENQ, 32'sh1, 32'sh1);
        repeat (5) offer(MODE_DEQ, '1, '1);

        // random: phases that lean toward filling, draining or neither
        enq_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 15;
                    default: enq_pct = 50;
                endcase
            end
            steady = (n >= 350 && n < 500);
            op = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
            if (op == MODE_ENQ)
                offer(op, $urandom, pick_priority());
            else
                offer(op, $urandom, $urandom);
        end
        in_valid <= 1'b0;

        while (result_count < sent)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d operations sent, %0d results compared", sent, result_count);
        $display("%0d empty dequeues and %0d dropped enqueues seen", underflow_count,
                 overflow_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
sv/spq_pkg.sv
sv/spq_datapath.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue.sv
tb/sv/spq_order_check.sv
tb/sv/tb.sv
